/* hw/rtl/vpa_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vpa_pkg: shared types and constants of the variable partition allocator
// Operation and status codes, field widths and default pool geometry.
// ----------------------------------------------------------------------------
package vpa_pkg;

    localparam int unsigned DEF_POOL_SIZE    = 1024;
    localparam int unsigned DEF_MAX_SEGMENTS = 16;

    localparam int unsigned FUNC_W  = 2;
    localparam int unsigned OWNER_W = 8;
    localparam int unsigned REQ_W   = 11;
    localparam int unsigned STAT_W  = 2;
    localparam int unsigned ADDR_W  = 10;
    localparam int unsigned SIZE_W  = 11;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC   = 2'd0,
        FN_RELEASE = 2'd1,
        FN_QUERY   = 2'd2,
        FN_NONE    = 2'd3
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOFIT   = 2'd1,
        ST_FULL    = 2'd2,
        ST_NOOWNER = 2'd3
    } t_status;

    // APB register map (byte address bit 2 selects the register word)
    localparam logic REG_FIT_POLICY = 1'b0;

endpackage
`default_nettype wire

/* hw/rtl/vpa_if.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// vpa_if: request and response channels of the allocator
// Valid/ready channels; a word moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface vpa_req_if;
    logic                         valid;
    logic                         ready;
    logic [vpa_pkg::FUNC_W-1:0]   func;
    logic [vpa_pkg::OWNER_W-1:0]  owner_id;
    logic [vpa_pkg::REQ_W-1:0]    request_size;

    modport source (output valid, func, owner_id, request_size, input ready);
    modport sink   (input valid, func, owner_id, request_size, output ready);
endinterface

interface vpa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [vpa_pkg::STAT_W-1:0]   status;
    logic [vpa_pkg::ADDR_W-1:0]   start_address;
    logic [vpa_pkg::SIZE_W-1:0]   segment_size;

    modport source (output valid, status, start_address, segment_size, input ready);
    modport sink   (input valid, status, start_address, segment_size, output ready);
endinterface
`default_nettype wire

/* hw/rtl/variable_partition_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// variable_partition_allocator: first/best fit allocator with coalescing
// Address-ordered segment table in a one-read/one-write memory, walked by a
// small sequencer for allocate, release (with merge) and owner query.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  i_req     in   valid/ready      func, owner_id, request_size
//  o_rsp     out  valid/ready      status, start_address, segment_size
//  apb       in   psel/penable     fit_policy at byte address 0
//
//  Trivial answers (func 3, owner 0, size 0) skip the table; query and release
//  scan entries in order; allocate scans, then on a split moves later entries up
//  and writes two entries; a release hit writes the merged entry and moves later
//  entries down. The single table read port moves one entry a cycle.
//  After reset the S_INIT state writes the initial free segment before i_req.ready.
//  i_req is taken only between items; a held o_rsp word stalls the finish.
// ----------------------------------------------------------------------------
module variable_partition_allocator #(
    parameter int unsigned POOL_SIZE    = vpa_pkg::DEF_POOL_SIZE,
    parameter int unsigned MAX_SEGMENTS = vpa_pkg::DEF_MAX_SEGMENTS
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    vpa_req_if.sink          i_req,
    vpa_rsp_if.source        o_rsp,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int unsigned SW  = $clog2(POOL_SIZE);
    localparam int unsigned LW  = $clog2(POOL_SIZE + 1);
    localparam int unsigned CW  = (LW > vpa_pkg::REQ_W) ? LW : vpa_pkg::REQ_W;
    localparam int unsigned IW  = $clog2(MAX_SEGMENTS);
    localparam int unsigned CNW = $clog2(MAX_SEGMENTS + 1);
    localparam int unsigned CXW = CNW + 1;

    typedef struct packed {
        logic                        busy;
        logic [vpa_pkg::OWNER_W-1:0] owner;
        logic [LW-1:0]               len;
        logic [SW-1:0]               start;
    } t_seg;

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_ADEC, S_SHUP_RD, S_SHUP, S_INS_A, S_INS_B,
        S_REL, S_SHDN_RD, S_SHDN, S_EMIT
    } t_state;

    // ---------------- configuration ----------------
    logic r_pol;
    logic cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == vpa_pkg::REG_FIT_POLICY);
    assign prdata = (paddr[2] == vpa_pkg::REG_FIT_POLICY) ? {31'd0, r_pol} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol <= 1'b1;
        end else if (cfg_wr) begin
            r_pol <= pwdata[0];
        end
    end

    // ---------------- segment table ----------------
    t_seg           mem [MAX_SEGMENTS];
    t_seg           r_rd;
    logic           we;
    logic [IW-1:0]  wa;
    t_seg           wd;
    logic [IW-1:0]  rd_addr;

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        r_rd <= mem[rd_addr];
    end

    // ---------------- sequencer ----------------
    t_state                       r_state, n_state;
    logic [CNW-1:0]               r_cnt, n_cnt;
    logic [IW-1:0]                r_idx, n_idx;
    logic [IW-1:0]                r_j, n_j;
    logic [IW-1:0]                r_pick, n_pick;
    logic [1:0]                   r_gap, n_gap;
    logic [vpa_pkg::FUNC_W-1:0]   r_func, n_func;
    logic [vpa_pkg::OWNER_W-1:0]  r_owner, n_owner;
    logic [vpa_pkg::REQ_W-1:0]    r_size, n_size;
    logic                         r_found, n_found;
    logic [LW-1:0]                r_best, n_best;
    t_seg                         r_pk, n_pk;
    t_seg                         r_prev, n_prev;
    logic [vpa_pkg::STAT_W-1:0]   r_res_st, n_res_st;
    logic [SW-1:0]                r_res_start, n_res_start;
    logic [LW-1:0]                r_res_len, n_res_len;
    logic                         r_ovalid, n_ovalid;
    logic [vpa_pkg::STAT_W-1:0]   r_ost, n_ost;
    logic [vpa_pkg::ADDR_W-1:0]   r_oaddr, n_oaddr;
    logic [vpa_pkg::SIZE_W-1:0]   r_osize, n_osize;

    logic           accept;
    logic           c_fit, c_hit, c_last, c_nf, c_pf;
    logic [LW-1:0]  c_left, c_mlen;
    logic [SW-1:0]  c_mstart;
    logic [1:0]     c_gap;
    logic [CXW-1:0] c_src;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;

    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.status        = r_ost;
    assign o_rsp.start_address = r_oaddr;
    assign o_rsp.segment_size  = r_osize;

    assign c_fit    = !r_rd.busy && (CW'(r_rd.len) >= CW'(r_size));
    assign c_left   = r_rd.len - LW'(r_size);
    assign c_hit    = r_rd.busy && (r_rd.owner == r_owner);
    assign c_last   = (CNW'(r_idx) == r_cnt - CNW'(1));
    // neighbors of the released entry: r_rd holds the next one, r_prev the one before
    assign c_nf     = (CXW'(r_pick) + CXW'(1) < CXW'(r_cnt)) && !r_rd.busy;
    assign c_pf     = (r_pick != '0) && !r_prev.busy;
    assign c_mlen   = r_pk.len + (c_nf ? r_rd.len : '0) + (c_pf ? r_prev.len : '0);
    assign c_mstart = c_pf ? r_prev.start : r_pk.start;
    assign c_gap    = 2'(c_nf) + 2'(c_pf);
    assign c_src    = CXW'(r_pick) + CXW'(1) + CXW'(c_nf);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_j         = r_j;
        n_pick      = r_pick;
        n_gap       = r_gap;
        n_func      = r_func;
        n_owner     = r_owner;
        n_size      = r_size;
        n_found     = r_found;
        n_best      = r_best;
        n_pk        = r_pk;
        n_prev      = r_prev;
        n_res_st    = r_res_st;
        n_res_start = r_res_start;
        n_res_len   = r_res_len;
        n_ovalid    = r_ovalid && !o_rsp.ready;
        n_ost       = r_ost;
        n_oaddr     = r_oaddr;
        n_osize     = r_osize;
        we          = 1'b0;
        wa          = r_idx;
        wd          = r_rd;
        rd_addr     = r_idx + IW'(1);

        case (r_state)
            S_INIT: begin
                we      = 1'b1;
                wa      = '0;
                wd      = '{busy: 1'b0, owner: '0, len: LW'(POOL_SIZE), start: '0};
                n_cnt   = CNW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                rd_addr = '0;
                if (accept) begin
                    n_func      = i_req.func;
                    n_owner     = i_req.owner_id;
                    n_size      = i_req.request_size;
                    n_idx       = '0;
                    n_found     = 1'b0;
                    n_best      = '0;
                    n_res_start = '0;
                    n_res_len   = '0;
                    if (i_req.func == vpa_pkg::FN_NONE) begin
                        n_res_st = vpa_pkg::ST_OK;
                        n_state  = S_EMIT;
                    end else if (i_req.owner_id == '0) begin
                        n_res_st = vpa_pkg::ST_NOOWNER;
                        n_state  = S_EMIT;
                    end else if (i_req.func == vpa_pkg::FN_ALLOC
                                 && i_req.request_size == '0) begin
                        n_res_st = vpa_pkg::ST_NOFIT;
                        n_state  = S_EMIT;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (r_func == vpa_pkg::FN_ALLOC) begin
                    if (c_fit && (!r_pol || !r_found || c_left < r_best)) begin
                        n_pick  = r_idx;
                        n_pk    = r_rd;
                        n_best  = c_left;
                        n_found = 1'b1;
                    end
                    if ((c_fit && !r_pol) || c_last) begin
                        n_state = S_ADEC;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end else if (c_hit) begin
                    n_pick  = r_idx;
                    n_pk    = r_rd;
                    n_found = 1'b1;
                    if (r_func == vpa_pkg::FN_QUERY) begin
                        n_res_st    = vpa_pkg::ST_OK;
                        n_res_start = r_rd.start;
                        n_res_len   = r_rd.len;
                        n_state     = S_EMIT;
                    end else begin
                        n_state = S_REL;
                    end
                end else begin
                    n_prev = r_rd;
                    if (c_last) begin
                        n_res_st = vpa_pkg::ST_NOOWNER;
                        n_state  = S_EMIT;
                    end else begin
                        n_idx = r_idx + IW'(1);
                    end
                end
            end
            S_ADEC: begin
                if (!r_found) begin
                    n_res_st = vpa_pkg::ST_NOFIT;
                    n_state  = S_EMIT;
                end else if (CW'(r_pk.len) == CW'(r_size)) begin
                    we          = 1'b1;
                    wa          = r_pick;
                    wd          = '{busy: 1'b1, owner: r_owner, len: r_pk.len,
                                    start: r_pk.start};
                    n_res_st    = vpa_pkg::ST_OK;
                    n_res_start = r_pk.start;
                    n_res_len   = r_pk.len;
                    n_state     = S_EMIT;
                end else if (CXW'(r_cnt) >= CXW'(MAX_SEGMENTS)) begin
                    n_res_st = vpa_pkg::ST_FULL;
                    n_state  = S_EMIT;
                end else if (CXW'(r_pick) + CXW'(2) <= CXW'(r_cnt)) begin
                    n_j     = IW'(r_cnt - CNW'(1));
                    n_state = S_SHUP_RD;
                end else begin
                    n_state = S_INS_A;
                end
            end
            S_SHUP_RD: begin
                rd_addr = r_j;
                n_state = S_SHUP;
            end
            S_SHUP: begin
                // move one entry up per cycle, top first
                we      = 1'b1;
                wa      = r_j + IW'(1);
                wd      = r_rd;
                rd_addr = r_j - IW'(1);
                if (r_j == r_pick + IW'(1)) begin
                    n_state = S_INS_A;
                end else begin
                    n_j = r_j - IW'(1);
                end
            end
            S_INS_A: begin
                we      = 1'b1;
                wa      = r_pick;
                wd      = '{busy: 1'b1, owner: r_owner, len: LW'(r_size),
                            start: r_pk.start};
                n_state = S_INS_B;
            end
            S_INS_B: begin
                we          = 1'b1;
                wa          = r_pick + IW'(1);
                wd          = '{busy: 1'b0, owner: '0, len: r_pk.len - LW'(r_size),
                                start: r_pk.start + SW'(r_size)};
                n_cnt       = r_cnt + CNW'(1);
                n_res_st    = vpa_pkg::ST_OK;
                n_res_start = r_pk.start;
                n_res_len   = LW'(r_size);
                n_state     = S_EMIT;
            end
            S_REL: begin
                we          = 1'b1;
                wa          = c_pf ? r_pick - IW'(1) : r_pick;
                wd          = '{busy: 1'b0, owner: '0, len: c_mlen, start: c_mstart};
                n_gap       = c_gap;
                n_res_st    = vpa_pkg::ST_OK;
                n_res_start = c_mstart;
                n_res_len   = c_mlen;
                if (c_gap != 2'd0 && c_src < CXW'(r_cnt)) begin
                    n_j     = IW'(c_src);
                    n_state = S_SHDN_RD;
                end else begin
                    n_cnt   = r_cnt - CNW'(c_gap);
                    n_state = S_EMIT;
                end
            end
            S_SHDN_RD: begin
                rd_addr = r_j;
                n_state = S_SHDN;
            end
            S_SHDN: begin
                // close the gap left by merged entries, bottom first
                we      = 1'b1;
                wa      = r_j - IW'(r_gap);
                wd      = r_rd;
                rd_addr = r_j + IW'(1);
                if (CNW'(r_j) == r_cnt - CNW'(1)) begin
                    n_cnt   = r_cnt - CNW'(r_gap);
                    n_state = S_EMIT;
                end else begin
                    n_j = r_j + IW'(1);
                end
            end
            S_EMIT: begin
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid = 1'b1;
                    n_ost    = r_res_st;
                    n_oaddr  = vpa_pkg::ADDR_W'(r_res_start);
                    n_osize  = vpa_pkg::SIZE_W'(r_res_len);
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_cnt    <= CNW'(1);
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_ovalid <= n_ovalid;
        end
        r_idx       <= n_idx;
        r_j         <= n_j;
        r_pick      <= n_pick;
        r_gap       <= n_gap;
        r_func      <= n_func;
        r_owner     <= n_owner;
        r_size      <= n_size;
        r_found     <= n_found;
        r_best      <= n_best;
        r_pk        <= n_pk;
        r_prev      <= n_prev;
        r_res_st    <= n_res_st;
        r_res_start <= n_res_start;
        r_res_len   <= n_res_len;
        r_ost       <= n_ost;
        r_oaddr     <= n_oaddr;
        r_osize     <= n_osize;
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt >= CNW'(1) && CXW'(r_cnt) <= CXW'(MAX_SEGMENTS))
        else $error("segment count out of range");

    a_scan_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SCAN |-> CNW'(r_idx) < r_cnt)
        else $error("scan index beyond table");

    a_full_only_at_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT && r_res_st == vpa_pkg::ST_FULL)
            |-> CXW'(r_cnt) == CXW'(MAX_SEGMENTS))
        else $error("table full reported below capacity");
`endif

endmodule
`default_nettype wire
